// ===== rtl/csl_pkg.sv =====
// Shared types, token codes and character tables for the C subset lexer.
// Used by csl_scan, csl_outq and c_subset_lexer; depends on nothing else.
package csl_pkg;

	// Default sizes of the stored position, length and keyword buffer.
	localparam int CslLineBitsDef    = 16;
	localparam int CslLengthBitsDef  = 8;
	localparam int CslKeywordCharsDef = 8;

	// Fixed widths of the token fields on the output port.
	localparam int TokLineBits   = 16;
	localparam int TokLengthBits = 8;

	// Longest keyword, and the packed width of the compared word.
	localparam int KwMaxLen  = 8;
	localparam int KwWordBits = KwMaxLen * 8;
	localparam int KwCount   = 10;

	// Depth of the result queue.
	localparam int OutqDepth = 4;

	// Token kind codes.
	localparam logic [5:0] TK_END       = 6'd0;
	localparam logic [5:0] TK_NUMBER    = 6'd1;
	localparam logic [5:0] TK_IDENT     = 6'd2;
	localparam logic [5:0] TK_PLUS      = 6'd3;
	localparam logic [5:0] TK_MINUS     = 6'd4;
	localparam logic [5:0] TK_STAR      = 6'd5;
	localparam logic [5:0] TK_DIVIDE    = 6'd6;
	localparam logic [5:0] TK_LPAREN    = 6'd7;
	localparam logic [5:0] TK_RPAREN    = 6'd8;
	localparam logic [5:0] TK_LBRACE    = 6'd9;
	localparam logic [5:0] TK_RBRACE    = 6'd10;
	localparam logic [5:0] TK_LBRACKET  = 6'd11;
	localparam logic [5:0] TK_RBRACKET  = 6'd12;
	localparam logic [5:0] TK_SEMI      = 6'd13;
	localparam logic [5:0] TK_COMMA     = 6'd14;
	localparam logic [5:0] TK_ASSIGN    = 6'd15;
	localparam logic [5:0] TK_EQ        = 6'd16;
	localparam logic [5:0] TK_NE        = 6'd17;
	localparam logic [5:0] TK_LT        = 6'd18;
	localparam logic [5:0] TK_LE        = 6'd19;
	localparam logic [5:0] TK_GT        = 6'd20;
	localparam logic [5:0] TK_GE        = 6'd21;
	localparam logic [5:0] TK_AND       = 6'd22;
	localparam logic [5:0] TK_OR        = 6'd23;
	localparam logic [5:0] TK_NOT       = 6'd24;
	localparam logic [5:0] TK_INVALID   = 6'd25;
	localparam logic [5:0] TK_KW_FIRST  = 6'd26;

	// Input item kinds.
	localparam logic ITEM_BYTE = 1'b0;
	localparam logic ITEM_EOS  = 1'b1;

	// Characters with a role of their own.
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_UNDER = 8'h5F;

	// Operator classes held while the second character is awaited.
	localparam logic [2:0] OP_ASSIGN = 3'd0;
	localparam logic [2:0] OP_BANG   = 3'd1;
	localparam logic [2:0] OP_LESS   = 3'd2;
	localparam logic [2:0] OP_GREAT  = 3'd3;
	localparam logic [2:0] OP_AMP    = 3'd4;
	localparam logic [2:0] OP_PIPE   = 3'd5;

	typedef struct packed {
		logic       kind;
		logic [7:0] char_code;
	} lex_in_t;

	typedef struct packed {
		logic [5:0]               token_kind;
		logic [TokLineBits-1:0]   first_line;
		logic [TokLineBits-1:0]   first_col;
		logic [TokLengthBits-1:0] token_length;
		logic [7:0]               bad_char;
		logic                     last_in_run;
	} token_t;

	// Up to two tokens produced by one item, first in order at tok0.
	typedef struct packed {
		logic [1:0] count;
		token_t     tok0;
		token_t     tok1;
	} scan_res_t;

	// Keyword texts, left aligned in the compared word, first character on top.
	localparam logic [KwWordBits-1:0] KW_TEXT [KwCount] = '{
		{"int",      40'h0},
		{"void",     32'h0},
		{"return",   16'h0},
		{"if",       48'h0},
		{"else",     32'h0},
		{"while",    24'h0},
		{"for",      40'h0},
		{"do",       48'h0},
		{"break",    24'h0},
		{"continue"}
	};
	localparam logic [3:0] KW_LEN [KwCount] = '{
		4'd3, 4'd4, 4'd6, 4'd2, 4'd4, 4'd5, 4'd3, 4'd2, 4'd5, 4'd8
	};

	// Keyword kind of an identifier word of the given length, else Identifier.
	function automatic logic [5:0] kw_lookup(input logic [KwWordBits-1:0] word,
		input logic [3:0] len);
		logic [KwWordBits-1:0] mask;
		logic [5:0]            kind;
		kind = TK_IDENT;
		for (int i = 0; i < KwCount; i++) begin
			mask = '0;
			for (int j = 0; j < KwMaxLen; j++) begin
				if (j < int'(KW_LEN[i])) begin
					mask[KwWordBits-1-8*j -: 8] = 8'hFF;
				end
			end
			if (len == KW_LEN[i] && ((word ^ KW_TEXT[i]) & mask) == '0) begin
				kind = TK_KW_FIRST + 6'(i);
			end
		end
		return kind;
	endfunction

	// Character that completes a two-character operator.
	function automatic logic [7:0] op_second(input logic [2:0] op);
		logic [7:0] c;
		unique case (op)
			OP_AMP:  c = "&";
			OP_PIPE: c = "|";
			default: c = "=";
		endcase
		return c;
	endfunction

	// Kind of an operator that stands alone.
	function automatic logic [5:0] op_single_kind(input logic [2:0] op);
		logic [5:0] k;
		unique case (op)
			OP_ASSIGN: k = TK_ASSIGN;
			OP_BANG:   k = TK_NOT;
			OP_LESS:   k = TK_LT;
			OP_GREAT:  k = TK_GT;
			default:   k = TK_INVALID;
		endcase
		return k;
	endfunction

	// Kind of a completed two-character operator.
	function automatic logic [5:0] op_double_kind(input logic [2:0] op);
		logic [5:0] k;
		unique case (op)
			OP_ASSIGN: k = TK_EQ;
			OP_BANG:   k = TK_NE;
			OP_LESS:   k = TK_LE;
			OP_GREAT:  k = TK_GE;
			OP_AMP:    k = TK_AND;
			default:   k = TK_OR;
		endcase
		return k;
	endfunction

endpackage

// ===== rtl/c_subset_lexer.sv =====
// Top level of the C subset lexer: input register, scanner and result queue.
// Depends on csl_pkg, csl_scan and csl_outq.
//
// Usage: one input item per transfer on the byte channel (byte_valid,
// byte_stall, byte_data). An item is a source byte or an end-of-source
// mark. Tokens leave one per transfer on the token channel (token_valid,
// token_stall, token_data); last_in_run marks the last token an item gave.
// An item gives zero, one or two tokens; end of source gives any pending
// token, then End, and restarts line and column at 1.
// An accepted item is held in the input register, scanned once the queue has
// room, and its tokens are written into the queue, from which they are taken.
// Throughput: one item per cycle while the queue has room, set by the single
// scan step per item; a run of two-token items is limited by the token
// channel at one token per cycle, and the scanner waits while the four-entry
// queue has fewer than two free entries.
// Reset clears the scanner to its start state and empties the queue; no
// clearing pass is needed. When the receiver stalls, tokens wait in the
// queue, and byte_stall rises once the queue cannot take a further item.
module c_subset_lexer import csl_pkg::*; #(
	parameter int LINE_BITS     = CslLineBitsDef,
	parameter int LENGTH_BITS   = CslLengthBitsDef,
	parameter int KEYWORD_CHARS = CslKeywordCharsDef
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    byte_valid,
	output logic    byte_stall,
	input  lex_in_t byte_data,
	output logic    token_valid,
	input  logic    token_stall,
	output token_t  token_data
);

	logic      valid_s1;
	lex_in_t   item_s1;
	logic      room;
	logic      step;
	logic      take;
	scan_res_t res;

	// The registered item is scanned whenever the queue has room.
	assign step       = valid_s1 && room;
	assign byte_stall = valid_s1 && !room;
	assign take       = byte_valid && !byte_stall;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= byte_data;
		end
	end

	csl_scan #(
		.LINE_BITS     (LINE_BITS),
		.LENGTH_BITS   (LENGTH_BITS),
		.KEYWORD_CHARS (KEYWORD_CHARS)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.res    (res)
	);

	csl_outq u_outq (
		.clk         (clk),
		.arst_n      (arst_n),
		.res         (res),
		.room        (room),
		.token_valid (token_valid),
		.token_stall (token_stall),
		.token_data  (token_data)
	);

	a_take_loads: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> valid_s1)
		else $error("accepted item not held in the input register");

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !step && !take) |=> (valid_s1 && $stable(item_s1)))
		else $error("waiting item lost from the input register");

	a_token_held: assert property (@(posedge clk) disable iff (!arst_n)
		(token_valid && token_stall) |=> (token_valid && $stable(token_data)))
		else $error("stalled token changed or dropped");

endmodule

// ===== rtl/csl_scan.sv =====
// Scanner state and the per-item step of the C subset lexer.
// Depends on csl_pkg for token types, codes and keyword tables.
module csl_scan import csl_pkg::*; #(
	parameter int LINE_BITS     = CslLineBitsDef,
	parameter int LENGTH_BITS   = CslLengthBitsDef,
	parameter int KEYWORD_CHARS = CslKeywordCharsDef
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,
	input  lex_in_t   item,
	output scan_res_t res
);

	localparam int KwIdxBits = $clog2(KEYWORD_CHARS);

	typedef enum logic [2:0] {
		M_START   = 3'd0,
		M_NUMBER  = 3'd1,
		M_IDENT   = 3'd2,
		M_OP      = 3'd3,
		M_SLASH   = 3'd4,
		M_COMMENT = 3'd5
	} mode_t;

	mode_t                  mode_q, mode_d;
	logic [2:0]             op_q, op_d;
	logic [LINE_BITS-1:0]   sline_q, sline_d, scol_q, scol_d;
	logic [LINE_BITS-1:0]   line_q, line_d, col_q, col_d;
	logic [LENGTH_BITS-1:0] run_q, run_d;
	logic [7:0]             word_q [KEYWORD_CHARS];

	logic                   wr_en;
	logic [KwIdxBits-1:0]   wr_idx;

	logic [7:0]             b;
	logic                   is_nl, is_ws, is_dig, is_alp, is_slash, op_hit;
	logic [2:0]             op_idx;
	logic [KwWordBits-1:0]  word;
	logic [5:0]             ident_kind;
	token_t                 fresh_tok, flush_tok, slot_b;
	logic                   fresh_emit, flush_emit, do_flush, do_fresh, slot_b_vld;
	logic                   slot_a_vld;

	// Classify the byte and form the token it gives when nothing is pending.
	always_comb begin
		b        = item.char_code;
		is_nl    = (b == CH_NL);
		is_ws    = (b == CH_SPACE) || (b == CH_TAB) || is_nl || (b == CH_CR);
		is_dig   = (b >= "0") && (b <= "9");
		is_alp   = ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z")) ||
			(b == CH_UNDER);
		is_slash = (b == CH_SLASH);
		op_hit   = 1'b1;
		op_idx   = OP_ASSIGN;
		unique case (b)
			"=":     op_idx = OP_ASSIGN;
			"!":     op_idx = OP_BANG;
			"<":     op_idx = OP_LESS;
			">":     op_idx = OP_GREAT;
			"&":     op_idx = OP_AMP;
			"|":     op_idx = OP_PIPE;
			default: op_hit = 1'b0;
		endcase

		fresh_tok              = '0;
		fresh_tok.first_line   = TokLineBits'(line_q);
		fresh_tok.first_col    = TokLineBits'(col_q);
		fresh_tok.token_length = TokLengthBits'(1);
		unique case (b)
			"+":     fresh_tok.token_kind = TK_PLUS;
			"-":     fresh_tok.token_kind = TK_MINUS;
			"*":     fresh_tok.token_kind = TK_STAR;
			"(":     fresh_tok.token_kind = TK_LPAREN;
			")":     fresh_tok.token_kind = TK_RPAREN;
			"{":     fresh_tok.token_kind = TK_LBRACE;
			"}":     fresh_tok.token_kind = TK_RBRACE;
			"[":     fresh_tok.token_kind = TK_LBRACKET;
			"]":     fresh_tok.token_kind = TK_RBRACKET;
			";":     fresh_tok.token_kind = TK_SEMI;
			",":     fresh_tok.token_kind = TK_COMMA;
			default: begin
				fresh_tok.token_kind = TK_INVALID;
				fresh_tok.bad_char   = b;
			end
		endcase
		fresh_emit = !(is_ws || is_dig || is_alp || is_slash || op_hit);
	end

	// Keyword check over the first characters of the identifier.
	always_comb begin
		for (int j = 0; j < KwMaxLen; j++) begin
			word[KwWordBits-1-8*j -: 8] = word_q[j];
		end
		if (32'(run_q) <= KwMaxLen) begin
			ident_kind = kw_lookup(word, run_q[3:0]);
		end else begin
			ident_kind = TK_IDENT;
		end
	end

	// Token closed by a byte that cannot extend the pending one.
	always_comb begin
		flush_tok              = '0;
		flush_tok.first_line   = TokLineBits'(sline_q);
		flush_tok.first_col    = TokLineBits'(scol_q);
		flush_tok.token_length = TokLengthBits'(1);
		flush_emit             = 1'b1;
		unique case (mode_q)
			M_NUMBER: begin
				flush_tok.token_kind   = TK_NUMBER;
				flush_tok.token_length = TokLengthBits'(run_q);
			end
			M_IDENT: begin
				flush_tok.token_kind   = ident_kind;
				flush_tok.token_length = TokLengthBits'(run_q);
			end
			M_OP:    flush_tok.token_kind = op_single_kind(op_q);
			M_SLASH: flush_tok.token_kind = TK_DIVIDE;
			default: flush_emit = 1'b0;
		endcase
	end

	// Next state and the tokens of this item.
	always_comb begin
		mode_d     = mode_q;
		op_d       = op_q;
		sline_d    = sline_q;
		scol_d     = scol_q;
		run_d      = run_q;
		line_d     = line_q;
		col_d      = col_q;
		wr_en      = 1'b0;
		wr_idx     = run_q[KwIdxBits-1:0];
		do_flush   = 1'b0;
		do_fresh   = 1'b0;
		slot_b     = fresh_tok;
		slot_b_vld = 1'b0;

		if (item.kind == ITEM_EOS) begin
			// End of source: close what is pending, give End, restart.
			do_flush                = 1'b1;
			slot_b                  = '0;
			slot_b.token_kind       = TK_END;
			slot_b.first_line       = TokLineBits'(line_q);
			slot_b.first_col        = TokLineBits'(col_q);
			slot_b_vld              = 1'b1;
			mode_d                  = M_START;
			op_d                    = OP_ASSIGN;
			sline_d                 = LINE_BITS'(1);
			scol_d                  = LINE_BITS'(1);
			run_d                   = '0;
			line_d                  = LINE_BITS'(1);
			col_d                   = LINE_BITS'(1);
		end else begin
			unique case (mode_q)
				M_NUMBER: begin
					if (is_dig) begin
						if (run_q != '1) run_d = run_q + 1'b1;
					end else begin
						do_flush = 1'b1;
						do_fresh = 1'b1;
					end
				end
				M_IDENT: begin
					if (is_alp || is_dig) begin
						wr_en = (32'(run_q) < KEYWORD_CHARS);
						if (run_q != '1) run_d = run_q + 1'b1;
					end else begin
						do_flush = 1'b1;
						do_fresh = 1'b1;
					end
				end
				M_OP: begin
					if (b == op_second(op_q)) begin
						slot_b                  = '0;
						slot_b.token_kind       = op_double_kind(op_q);
						slot_b.first_line       = TokLineBits'(sline_q);
						slot_b.first_col        = TokLineBits'(scol_q);
						slot_b.token_length     = TokLengthBits'(2);
						slot_b_vld              = 1'b1;
						mode_d                  = M_START;
					end else begin
						do_flush = 1'b1;
						do_fresh = 1'b1;
					end
				end
				M_SLASH: begin
					if (is_slash) begin
						mode_d = M_COMMENT;
					end else begin
						do_flush = 1'b1;
						do_fresh = 1'b1;
					end
				end
				M_COMMENT: do_fresh = is_nl;
				default:   do_fresh = 1'b1;
			endcase

			// A byte looked at afresh may open a new token.
			if (do_fresh) begin
				slot_b_vld = fresh_emit;
				mode_d     = M_START;
				if (is_dig || is_alp || is_slash || op_hit) begin
					sline_d = line_q;
					scol_d  = col_q;
					run_d   = LENGTH_BITS'(1);
				end
				if (is_dig) mode_d = M_NUMBER;
				if (is_slash) mode_d = M_SLASH;
				if (is_alp) begin
					mode_d = M_IDENT;
					wr_en  = 1'b1;
					wr_idx = '0;
				end
				if (op_hit) begin
					mode_d = M_OP;
					op_d   = op_idx;
				end
			end

			// Position of the next byte, saturating.
			if (is_nl) begin
				if (line_q != '1) line_d = line_q + 1'b1;
				col_d = LINE_BITS'(1);
			end else if (col_q != '1) begin
				col_d = col_q + 1'b1;
			end
		end

		// Pack the tokens in order and mark the last one.
		slot_a_vld = do_flush && flush_emit;
		res.count  = {1'b0, slot_a_vld} + {1'b0, slot_b_vld};
		res.tok0   = slot_a_vld ? flush_tok : slot_b;
		res.tok1   = slot_b;
		res.tok0.last_in_run = !(slot_a_vld && slot_b_vld);
		res.tok1.last_in_run = 1'b1;
		if (!step) begin
			res.count = 2'd0;
		end
	end

	// Scanner state and position registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_START;
			op_q    <= OP_ASSIGN;
			sline_q <= LINE_BITS'(1);
			scol_q  <= LINE_BITS'(1);
			run_q   <= '0;
			line_q  <= LINE_BITS'(1);
			col_q   <= LINE_BITS'(1);
		end else if (step) begin
			mode_q  <= mode_d;
			op_q    <= op_d;
			sline_q <= sline_d;
			scol_q  <= scol_d;
			run_q   <= run_d;
			line_q  <= line_d;
			col_q   <= col_d;
		end
	end

	// Identifier characters kept for the keyword check.
	always_ff @(posedge clk) begin
		if (step && wr_en) begin
			word_q[wr_idx] <= b;
		end
	end

	a_op_class: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == M_OP) |-> (op_q <= OP_PIPE))
		else $error("pending operator class out of range");

	a_run_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == M_NUMBER || mode_q == M_IDENT) |-> (run_q != '0))
		else $error("open token with zero length");

	a_eos_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(step && item.kind == ITEM_EOS) |=> (mode_q == M_START && line_q == LINE_BITS'(1)
			&& col_q == LINE_BITS'(1)))
		else $error("end of source did not restart the scanner");

endmodule

// ===== rtl/csl_outq.sv =====
// Result queue of the C subset lexer: takes up to two tokens per cycle,
// hands out one per transfer. Depends on csl_pkg for the token type.
module csl_outq import csl_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  scan_res_t res,
	output logic      room,
	output logic      token_valid,
	input  logic      token_stall,
	output token_t    token_data
);

	localparam int PtrBits = $clog2(OutqDepth);
	localparam int CntBits = $clog2(OutqDepth + 1);

	token_t               mem_q [OutqDepth];
	logic [PtrBits-1:0]   wp_q, rp_q;
	logic [CntBits-1:0]   cnt_q;
	logic                 pop;

	// Room for the two tokens an item may give, before this cycle's read.
	assign room        = (32'(cnt_q) <= OutqDepth - 2);
	assign token_valid = (cnt_q != '0);
	assign token_data  = mem_q[rp_q];
	assign pop         = token_valid && !token_stall;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + PtrBits'(res.count);
			rp_q  <= rp_q + PtrBits'(pop);
			cnt_q <= cnt_q + CntBits'(res.count) - CntBits'(pop);
		end
	end

	// Token storage.
	always_ff @(posedge clk) begin
		if (res.count != 2'd0) begin
			mem_q[wp_q] <= res.tok0;
		end
		if (res.count == 2'd2) begin
			mem_q[wp_q + PtrBits'(1)] <= res.tok1;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(res.count != 2'd0) |-> room)
		else $error("token pushed without room");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) <= OutqDepth)
		else $error("queue count beyond depth");

	a_ptr_track: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0 || 32'(cnt_q) == OutqDepth) |-> (wp_q == rp_q))
		else $error("queue pointers disagree with count");

endmodule

// ===== bench/c_subset_lexer_check.sv =====
`timescale 1ns / 1ps
// Token checker for the C subset lexer: predicts the tokens of every accepted
// source item and compares each token transfer with the oldest one due.
// Depends on csl_pkg for the channel types, token kinds and character codes.
module c_subset_lexer_check import csl_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    byte_valid,
	input  logic    byte_stall,
	input  lex_in_t byte_data,
	input  logic    token_valid,
	input  logic    token_stall,
	input  token_t  token_data,
	output int      fail_count,
	output int      tokens_pending,
	output int      tokens_checked
);

	typedef enum logic [2:0] {
		LEX_IDLE, LEX_NUMBER, LEX_WORD, LEX_OP, LEX_SLASH, LEX_COMMENT
	} lex_mode_e;

	localparam logic [5:0] KW_INT      = TK_KW_FIRST + 6'd0;
	localparam logic [5:0] KW_VOID     = TK_KW_FIRST + 6'd1;
	localparam logic [5:0] KW_RETURN   = TK_KW_FIRST + 6'd2;
	localparam logic [5:0] KW_IF       = TK_KW_FIRST + 6'd3;
	localparam logic [5:0] KW_ELSE     = TK_KW_FIRST + 6'd4;
	localparam logic [5:0] KW_WHILE    = TK_KW_FIRST + 6'd5;
	localparam logic [5:0] KW_FOR      = TK_KW_FIRST + 6'd6;
	localparam logic [5:0] KW_DO       = TK_KW_FIRST + 6'd7;
	localparam logic [5:0] KW_BREAK    = TK_KW_FIRST + 6'd8;
	localparam logic [5:0] KW_CONTINUE = TK_KW_FIRST + 6'd9;

	localparam logic [15:0] POS_TOP    = 16'hFFFF;
	localparam logic [7:0]  LEN_TOP    = 8'hFF;
	localparam int          WORD_CHARS = 8;

	// Scanner state as the lexer should hold it.
	lex_mode_e   lex_mode;
	logic [2:0]  held_op;
	logic [15:0] tok_line;
	logic [15:0] tok_col;
	logic [7:0]  tok_len;
	logic [7:0]  word_chars [WORD_CHARS];
	logic [15:0] line_now;
	logic [15:0] col_now;

	// Tokens of the item being predicted, and tokens still to arrive.
	token_t step_toks [2];
	int     step_n;
	token_t tokens_due [$];

	function automatic logic is_digit(input logic [7:0] b);
		return b >= "0" && b <= "9";
	endfunction

	function automatic logic is_alpha(input logic [7:0] b);
		return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == CH_UNDER;
	endfunction

	// Keyword kind of the buffered word, Identifier when it matches none.
	function automatic logic [5:0] word_kind();
		logic [63:0] w;
		logic [5:0]  k;
		w = {word_chars[0], word_chars[1], word_chars[2], word_chars[3],
			word_chars[4], word_chars[5], word_chars[6], word_chars[7]};
		k = TK_IDENT;
		case (tok_len)
			8'd2: begin
				if (w[63:48] == "if") k = KW_IF;
				else if (w[63:48] == "do") k = KW_DO;
			end
			8'd3: begin
				if (w[63:40] == "int") k = KW_INT;
				else if (w[63:40] == "for") k = KW_FOR;
			end
			8'd4: begin
				if (w[63:32] == "void") k = KW_VOID;
				else if (w[63:32] == "else") k = KW_ELSE;
			end
			8'd5: begin
				if (w[63:24] == "while") k = KW_WHILE;
				else if (w[63:24] == "break") k = KW_BREAK;
			end
			8'd6: begin
				if (w[63:16] == "return") k = KW_RETURN;
			end
			8'd8: begin
				if (w == "continue") k = KW_CONTINUE;
			end
			default: ;
		endcase
		return k;
	endfunction

	function automatic logic [7:0] pair_char(input logic [2:0] op);
		case (op)
			OP_AMP:  return "&";
			OP_PIPE: return "|";
			default: return "=";
		endcase
	endfunction

	function automatic logic [5:0] lone_kind(input logic [2:0] op);
		case (op)
			OP_ASSIGN: return TK_ASSIGN;
			OP_BANG:   return TK_NOT;
			OP_LESS:   return TK_LT;
			OP_GREAT:  return TK_GT;
			default:   return TK_INVALID;
		endcase
	endfunction

	function automatic logic [5:0] pair_kind(input logic [2:0] op);
		case (op)
			OP_ASSIGN: return TK_EQ;
			OP_BANG:   return TK_NE;
			OP_LESS:   return TK_LE;
			OP_GREAT:  return TK_GE;
			OP_AMP:    return TK_AND;
			default:   return TK_OR;
		endcase
	endfunction

	task automatic add_token(input logic [5:0] k, input logic [15:0] ln,
		input logic [15:0] col, input logic [7:0] len, input logic [7:0] bad);
		token_t t;
		t.token_kind   = k;
		t.first_line   = ln;
		t.first_col    = col;
		t.token_length = len;
		t.bad_char     = bad;
		t.last_in_run  = 1'b0;
		step_toks[step_n] = t;
		step_n++;
	endtask

	task automatic open_token(input lex_mode_e m);
		lex_mode = m;
		tok_line = line_now;
		tok_col  = col_now;
		tok_len  = 8'd1;
	endtask

	// Close the token held open, if any, and go back to idle.
	task automatic close_token();
		case (lex_mode)
			LEX_NUMBER: add_token(TK_NUMBER, tok_line, tok_col, tok_len, 8'd0);
			LEX_WORD:   add_token(word_kind(), tok_line, tok_col, tok_len, 8'd0);
			LEX_OP:     add_token(lone_kind(held_op), tok_line, tok_col, 8'd1, 8'd0);
			LEX_SLASH:  add_token(TK_DIVIDE, tok_line, tok_col, 8'd1, 8'd0);
			default: ;
		endcase
		lex_mode = LEX_IDLE;
	endtask

	// Look at a byte with nothing held open.
	task automatic scan_fresh(input logic [7:0] b);
		logic [5:0] k;
		lex_mode = LEX_IDLE;
		k = TK_INVALID;
		if (b == CH_SPACE || b == CH_TAB || b == CH_NL || b == CH_CR) begin
		end else if (is_digit(b)) begin
			open_token(LEX_NUMBER);
		end else if (is_alpha(b)) begin
			open_token(LEX_WORD);
			word_chars[0] = b;
		end else if (b == CH_SLASH) begin
			open_token(LEX_SLASH);
		end else if (b == "=" || b == "!" || b == "<" || b == ">" ||
			b == "&" || b == "|") begin
			open_token(LEX_OP);
			case (b)
				"=":     held_op = OP_ASSIGN;
				"!":     held_op = OP_BANG;
				"<":     held_op = OP_LESS;
				">":     held_op = OP_GREAT;
				"&":     held_op = OP_AMP;
				default: held_op = OP_PIPE;
			endcase
		end else begin
			case (b)
				"+": k = TK_PLUS;
				"-": k = TK_MINUS;
				"*": k = TK_STAR;
				"(": k = TK_LPAREN;
				")": k = TK_RPAREN;
				"{": k = TK_LBRACE;
				"}": k = TK_RBRACE;
				"[": k = TK_LBRACKET;
				"]": k = TK_RBRACKET;
				";": k = TK_SEMI;
				",": k = TK_COMMA;
				default: ;
			endcase
			// Unknown bytes carry themselves in bad_char.
			add_token(k, line_now, col_now, 8'd1, (k == TK_INVALID) ? b : 8'd0);
		end
	endtask

	task automatic clear_scan();
		lex_mode = LEX_IDLE;
		held_op  = OP_ASSIGN;
		tok_line = 16'd1;
		tok_col  = 16'd1;
		tok_len  = 8'd0;
		line_now = 16'd1;
		col_now  = 16'd1;
		for (int i = 0; i < WORD_CHARS; i++) word_chars[i] = 8'd0;
	endtask

	// Work out the tokens one accepted item causes and queue them.
	task automatic tokenize_item(input lex_in_t it);
		logic [7:0] b;
		b = it.char_code;
		step_n = 0;
		if (it.kind == ITEM_EOS) begin
			close_token();
			add_token(TK_END, line_now, col_now, 8'd0, 8'd0);
			clear_scan();
		end else begin
			case (lex_mode)
				LEX_NUMBER: begin
					if (is_digit(b)) begin
						if (tok_len != LEN_TOP) tok_len++;
					end else begin
						close_token();
						scan_fresh(b);
					end
				end
				LEX_WORD: begin
					if (is_alpha(b) || is_digit(b)) begin
						if (tok_len < WORD_CHARS) word_chars[tok_len] = b;
						if (tok_len != LEN_TOP) tok_len++;
					end else begin
						close_token();
						scan_fresh(b);
					end
				end
				LEX_OP: begin
					if (b == pair_char(held_op)) begin
						add_token(pair_kind(held_op), tok_line, tok_col, 8'd2, 8'd0);
						lex_mode = LEX_IDLE;
					end else begin
						close_token();
						scan_fresh(b);
					end
				end
				LEX_SLASH: begin
					if (b == CH_SLASH) begin
						lex_mode = LEX_COMMENT;
					end else begin
						close_token();
						scan_fresh(b);
					end
				end
				LEX_COMMENT: begin
					if (b == CH_NL) scan_fresh(b);
				end
				default: scan_fresh(b);
			endcase
			// Position of the next byte, saturating at the top.
			if (b == CH_NL) begin
				if (line_now != POS_TOP) line_now++;
				col_now = 16'd1;
			end else if (col_now != POS_TOP) begin
				col_now++;
			end
		end
		for (int i = 0; i < step_n; i++) begin
			if (i == step_n - 1) step_toks[i].last_in_run = 1'b1;
			tokens_due.push_back(step_toks[i]);
		end
	endtask

	task automatic report_mismatch(input string msg);
		$display("%0t: token mismatch: %s", $time, msg);
		fail_count++;
	endtask

	task automatic check_field(input string name, input int unsigned got,
		input int unsigned want);
		if (got != want)
			report_mismatch($sformatf("%s is %0d, %0d was due (token %0d)",
				name, got, want, tokens_checked));
	endtask

	task automatic check_token(input token_t got);
		token_t want;
		if (tokens_due.size() == 0) begin
			report_mismatch($sformatf("kind %0d line %0d col %0d arrived with none due",
				got.token_kind, got.first_line, got.first_col));
		end else begin
			want = tokens_due.pop_front();
			check_field("kind", got.token_kind, want.token_kind);
			check_field("line", got.first_line, want.first_line);
			check_field("column", got.first_col, want.first_col);
			check_field("length", got.token_length, want.token_length);
			check_field("bad_char", got.bad_char, want.bad_char);
			check_field("last_in_run", got.last_in_run, want.last_in_run);
		end
		tokens_checked++;
	endtask

	// Watch both channels; an item is predicted before any token is compared.
	always @(posedge clk) begin
		if (!arst_n) begin
			clear_scan();
			tokens_due.delete();
			fail_count     = 0;
			tokens_checked = 0;
		end else begin
			if (byte_valid && !byte_stall) tokenize_item(byte_data);
			if (token_valid && !token_stall) check_token(token_data);
		end
		tokens_pending = tokens_due.size();
	end

endmodule

// ===== bench/c_subset_lexer_test.sv =====
`timescale 1ns / 1ps
// Top of the C subset lexer testbench: clock, reset, source stimulus, token
// receiver with stalls, watchdog and verdict. Depends on csl_pkg, the lexer
// RTL and c_subset_lexer_check.
module c_subset_lexer_test;
	import csl_pkg::*;

	localparam int QUIET_LIMIT = 5000;
	localparam int HOLD_CYCLES = 300;
	localparam int TOTAL_ITEMS = 1800;
	localparam int LONG_RUN    = 260;

	logic    clk         = 1'b0;
	logic    arst_n      = 1'b0;
	logic    byte_valid  = 1'b0;
	lex_in_t byte_data   = '0;
	logic    token_stall = 1'b0;
	logic    byte_stall;
	logic    token_valid;
	token_t  token_data;

	int fail_count;
	int tokens_pending;
	int tokens_checked;

	bit calm      = 1'b0;
	bit hold_req  = 1'b0;
	bit hold_done = 1'b0;
	int stall_left   = 0;
	int items_sent   = 0;
	int quiet_cycles = 0;

	string kw_words [10] = '{"int", "void", "return", "if", "else", "while", "for",
		"do", "break", "continue"};
	string op_words [12] = '{"==", "!=", "<=", ">=", "&&", "||", "=", "!", "<", ">",
		"&", "|"};
	string punct_chars = "+-*/(){}[];,";

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	c_subset_lexer uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_valid  (byte_valid),
		.byte_stall  (byte_stall),
		.byte_data   (byte_data),
		.token_valid (token_valid),
		.token_stall (token_stall),
		.token_data  (token_data)
	);

	c_subset_lexer_check u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.byte_valid     (byte_valid),
		.byte_stall     (byte_stall),
		.byte_data      (byte_data),
		.token_valid    (token_valid),
		.token_stall    (token_stall),
		.token_data     (token_data),
		.fail_count     (fail_count),
		.tokens_pending (tokens_pending),
		.tokens_checked (tokens_checked)
	);

	// Token receiver: short random stall bursts, one long hold on request.
	always @(posedge clk) begin
		if (!arst_n) begin
			token_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left  <= stall_left - 1;
			token_stall <= 1'b1;
		end else if (hold_req && !hold_done) begin
			hold_done   <= 1'b1;
			stall_left  <= HOLD_CYCLES - 1;
			token_stall <= 1'b1;
		end else if (!calm && $urandom_range(0, 7) == 0) begin
			stall_left  <= $urandom_range(0, 8);
			token_stall <= 1'b1;
		end else begin
			token_stall <= 1'b0;
		end
	end

	// Watchdog: ends the run after too long without any transfer.
	initial begin
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
			if ((byte_valid && !byte_stall) || (token_valid && !token_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("Watchdog: no transfer for %0d cycles", QUIET_LIMIT);
		$display("Regression FAIL");
		$finish;
	end

	// Offer one item, at times after a random gap, and hold it until its transfer.
	task automatic send_item(input logic k, input logic [7:0] c);
		if (!calm && $urandom_range(0, 7) == 0) begin
			byte_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_data  <= lex_in_t'{kind: k, char_code: c};
		do @(posedge clk); while (byte_stall);
		items_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_item(ITEM_BYTE, s[i]);
	endtask

	function automatic logic [7:0] word_char(input bit lead);
		int r;
		r = $urandom_range(0, lead ? 52 : 62);
		if (r < 26) return "a" + 8'(r);
		if (r < 52) return "A" + 8'(r - 26);
		if (r == 52) return CH_UNDER;
		return "0" + 8'(r - 53);
	endfunction

	// One random piece of source: mostly well-formed tokens, some noise.
	task automatic send_fragment();
		int         pick;
		int         len;
		int         w;
		logic [7:0] c;
		pick = $urandom_range(0, 99);
		if (pick < 15) begin
			w = $urandom_range(0, 9);
			case ($urandom_range(0, 3))
				0: begin
					send_text(kw_words[w]);
					send_item(ITEM_BYTE, word_char(1'b0));
				end
				1: begin
					for (int i = 0; i < kw_words[w].len() - 1; i++)
						send_item(ITEM_BYTE, kw_words[w][i]);
				end
				default: send_text(kw_words[w]);
			endcase
		end else if (pick < 30) begin
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 5);
			send_item(ITEM_BYTE, word_char(1'b1));
			repeat (len - 1) send_item(ITEM_BYTE, word_char(1'b0));
		end else if (pick < 42) begin
			repeat ($urandom_range(1, 6)) send_item(ITEM_BYTE, "0" + 8'($urandom_range(0, 9)));
		end else if (pick < 57) begin
			send_text(op_words[$urandom_range(0, 11)]);
		end else if (pick < 70) begin
			send_item(ITEM_BYTE, punct_chars[$urandom_range(0, punct_chars.len() - 1)]);
		end else if (pick < 78) begin
			case ($urandom_range(0, 3))
				0: c = CH_SPACE;
				1: c = CH_TAB;
				2: c = CH_NL;
				default: c = CH_CR;
			endcase
			send_item(ITEM_BYTE, c);
		end else if (pick < 84) begin
			send_text("//");
			repeat ($urandom_range(0, 8)) begin
				c = 8'($urandom_range(0, 255));
				if (c == CH_NL) c = "q";
				send_item(ITEM_BYTE, c);
			end
			if ($urandom_range(0, 5) == 0) send_item(ITEM_EOS, 8'($urandom_range(0, 255)));
			else send_item(ITEM_BYTE, CH_NL);
		end else if (pick < 92) begin
			send_item(ITEM_BYTE, 8'($urandom_range(0, 255)));
		end else if (pick < 96) begin
			send_item(ITEM_EOS, 8'($urandom_range(0, 255)));
		end else begin
			send_item(ITEM_BYTE, CH_SLASH);
		end
		// Separator, or none so that the next byte closes this token.
		pick = $urandom_range(0, 9);
		if (pick < 5) send_item(ITEM_BYTE, CH_SPACE);
		else if (pick == 5) send_item(ITEM_BYTE, CH_NL);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: operators, comment, extreme bytes, lone & and |, slash at end,
		// end of source inside a comment.
		send_text("if(a<=9)x=y;//c\n");
		send_item(ITEM_BYTE, 8'h00);
		send_item(ITEM_BYTE, 8'hFF);
		send_text("&x|\t\r/");
		send_item(ITEM_EOS, 8'hFF);
		send_text("//z");
		send_item(ITEM_EOS, 8'h00);

		// Saturation of the token length, sent without gaps.
		calm <= 1'b1;
		repeat (LONG_RUN) send_item(ITEM_BYTE, "0" + 8'($urandom_range(0, 9)));
		send_item(ITEM_BYTE, CH_SPACE);
		send_item(ITEM_BYTE, word_char(1'b1));
		repeat (LONG_RUN) send_item(ITEM_BYTE, word_char(1'b0));
		send_item(ITEM_EOS, 8'h00);
		calm <= 1'b0;

		// Long receiver hold while the source keeps coming.
		hold_req <= 1'b1;
		repeat (20) send_text("x=y;");
		send_item(ITEM_EOS, 8'h00);

		// Random source, the last stretch without any idling.
		while (items_sent < TOTAL_ITEMS) begin
			if (items_sent > TOTAL_ITEMS - 300) calm <= 1'b1;
			send_fragment();
		end
		send_item(ITEM_EOS, 8'h00);
		byte_valid <= 1'b0;

		while (tokens_pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("Sent %0d source items, checked %0d tokens, %0d mismatches, %0d left due.",
			items_sent, tokens_checked, fail_count, tokens_pending);
		$display("Covered keywords, operators, comments, bad bytes, long tokens and a hold.");
		if (fail_count == 0 && tokens_pending == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
